### rtl/okvt_pkg.sv
// shared types, constants and codes for the ordered key/value table
package okvt_pkg;

   // default build sizes
   localparam int CAPACITY_DEFAULT    = 16;
   localparam int KEY_WIDTH_DEFAULT   = 32;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int COMMAND_WIDTH       = 3;

   // request commands
   typedef enum logic [COMMAND_WIDTH-1:0] {
      OP_INSERT           = 3'd0,
      OP_UPDATE           = 3'd1,
      OP_INSERT_OR_UPDATE = 3'd2,
      OP_ERASE            = 3'd3,
      OP_CONTAINS         = 3'd4,
      OP_GET_BY_KEY       = 3'd5,
      OP_GET_BY_INDEX     = 3'd6
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SHIFT,
      ST_IDX_READ,
      ST_IDX_CAPTURE,
      ST_RESPOND
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;        // latch request beat, clear result
      logic scan_begin;   // pointer to first entry
      logic seek_pos;     // pointer to requested position
      logic shift_begin;  // pointer to entry after the match
      logic step;         // issue read at pointer and advance
      logic shift_write;  // move lagging entry down by one
      logic cap_value;    // keep value of the matching entry
      logic cap_entry;    // keep key and value read by position
      logic set_ok;
      logic wr_append;    // write pair at the end, count up
      logic wr_update;    // overwrite value of the matching entry
      logic count_dec;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   pos_ok;
      logic   hit;
      logic   miss;
      logic   shift_end;
   } status_type;

endpackage

### rtl/ordered_key_value_table.sv
// top level of the ordered key/value table with linear key search
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  command, key, new_value, position
//   rsp      out        rsp_valid / rsp_stall  ok, found_key, found_value, entry_count, is_empty
//   csr      in         csr_valid / csr_ready  entry_limit
//
// one request at a time; get_by_index reads the store by position, the key commands
// run the one-read-per-cycle key scan, and erase then also shifts the entries after the
// match down by one through the store ram.
// reset is synchronous: count cleared, limit set to capacity, store contents kept.
// a stalled response holds in its register; the next request is taken meanwhile.
module ordered_key_value_table
   import okvt_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEFAULT,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COMMAND_WIDTH-1:0] req_command,
   input  logic [KEY_WIDTH-1:0]     req_key,
   input  logic [VALUE_WIDTH-1:0]   req_new_value,
   input  logic [IDX_W-1:0]         req_position,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_ok,
   output logic [KEY_WIDTH-1:0]     rsp_found_key,
   output logic [VALUE_WIDTH-1:0]   rsp_found_value,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_empty,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CNT_W-1:0]         csr_entry_limit
);

   cmd_type    cmd;
   status_type sts;

   // limit register takes a write every cycle
   assign csr_ready = 1'b1;

   okvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   okvt_datapath #(
      .CAPACITY    (CAPACITY),
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_new_value   (req_new_value),
      .req_position    (req_position),
      .csr_valid       (csr_valid),
      .csr_entry_limit (csr_entry_limit),
      .rsp_ok          (rsp_ok),
      .rsp_found_key   (rsp_found_key),
      .rsp_found_value (rsp_found_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

### rtl/okvt_ram.sv
// generic single write port ram with registered read
module okvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/okvt_ctrl.sv
// sequencer for the ordered key/value table
module okvt_ctrl
   import okvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and response valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.op)
               OP_INSERT: begin
                  if (sts.full) begin
                     state_in = ST_RESPOND;
                  end else begin
                     cmd.scan_begin = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               OP_UPDATE, OP_INSERT_OR_UPDATE, OP_ERASE, OP_CONTAINS, OP_GET_BY_KEY: begin
                  cmd.scan_begin = 1'b1;
                  state_in       = ST_SCAN;
               end
               OP_GET_BY_INDEX: begin
                  if (sts.pos_ok) begin
                     cmd.seek_pos = 1'b1;
                     state_in     = ST_IDX_READ;
                  end else begin
                     state_in = ST_RESPOND;
                  end
               end
               default: state_in = ST_RESPOND;
            endcase
         end
         ST_SCAN: begin
            if (sts.hit) begin
               state_in = ST_RESPOND;
               case (sts.op)
                  OP_UPDATE, OP_INSERT_OR_UPDATE: begin
                     cmd.wr_update = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
                  OP_ERASE: begin
                     cmd.shift_begin = 1'b1;
                     state_in        = ST_SHIFT;
                  end
                  OP_CONTAINS: cmd.set_ok = 1'b1;
                  OP_GET_BY_KEY: begin
                     cmd.cap_value = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
                  default: ;
               endcase
            end else if (sts.miss) begin
               state_in = ST_RESPOND;
               case (sts.op)
                  OP_INSERT: begin
                     cmd.wr_append = 1'b1;
                     cmd.set_ok    = 1'b1;
                  end
                  OP_INSERT_OR_UPDATE: begin
                     if (!sts.full) begin
                        cmd.wr_append = 1'b1;
                        cmd.set_ok    = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_SHIFT: begin
            if (sts.shift_end) begin
               cmd.count_dec = 1'b1;
               cmd.set_ok    = 1'b1;
               state_in      = ST_RESPOND;
            end else begin
               cmd.step        = 1'b1;
               cmd.shift_write = 1'b1;
            end
         end
         ST_IDX_READ: state_in = ST_IDX_CAPTURE;
         ST_IDX_CAPTURE: begin
            cmd.cap_entry = 1'b1;
            cmd.set_ok    = 1'b1;
            state_in      = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output slot: filled on load, emptied when the beat is taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_DISPATCH)
      else $error("accepted beat not dispatched");
   a_append_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |-> !sts.full)
      else $error("append into a full table");
   a_shift_only_erase: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> sts.op == OP_ERASE)
      else $error("shift outside erase");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !cmd.load_rsp)
      else $error("response slot overwritten while stalled");
`endif

endmodule

### rtl/okvt_datapath.sv
// key and value stores, scan pointer, count, limit and response registers
module okvt_datapath
   import okvt_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEFAULT,
   parameter int KEY_WIDTH   = KEY_WIDTH_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               sts,
   input  logic [COMMAND_WIDTH-1:0] req_command,
   input  logic [KEY_WIDTH-1:0]     req_key,
   input  logic [VALUE_WIDTH-1:0]   req_new_value,
   input  logic [IDX_W-1:0]         req_position,
   input  logic                     csr_valid,
   input  logic [CNT_W-1:0]         csr_entry_limit,
   output logic                     rsp_ok,
   output logic [KEY_WIDTH-1:0]     rsp_found_key,
   output logic [VALUE_WIDTH-1:0]   rsp_found_value,
   output logic [CNT_W-1:0]         rsp_entry_count,
   output logic                     rsp_is_empty
);

   // request fields held for the whole operation
   op_type                 op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [IDX_W-1:0]       pos_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] limit_ff;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] lag_idx_ff, lag_idx_in;
   logic             lag_valid_ff, lag_valid_in;

   logic                   res_ok_ff;
   logic [KEY_WIDTH-1:0]   res_key_ff;
   logic [VALUE_WIDTH-1:0] res_val_ff;

   logic                   rsp_ok_ff;
   logic [KEY_WIDTH-1:0]   rsp_key_ff;
   logic [VALUE_WIDTH-1:0] rsp_val_ff;
   logic [CNT_W-1:0]       rsp_count_ff;
   logic                   rsp_empty_ff;

   logic [KEY_WIDTH-1:0]   key_rd;
   logic [VALUE_WIDTH-1:0] val_rd;
   logic                   key_wr_en, val_wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [KEY_WIDTH-1:0]   key_wr_data;
   logic [VALUE_WIDTH-1:0] val_wr_data;
   logic [CNT_W-1:0]       shift_dst;
   logic [CNT_W-1:0]       eff_limit;
   logic                   exhausted;
   logic                   hit;
   logic                   shift_move;

   // request beat capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= op_type'(req_command);
         key_ff <= req_key;
         val_ff <= req_new_value;
         pos_ff <= req_position;
      end
   end

   // entry limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CNT_W'(CAPACITY);
      end else if (csr_valid) begin
         limit_ff <= csr_entry_limit;
      end
   end

   // status towards the sequencer
   assign eff_limit  = (limit_ff > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : limit_ff;
   assign exhausted  = (ptr_ff >= count_ff);
   assign hit        = lag_valid_ff && (key_rd == key_ff);
   assign shift_move = cmd.shift_write && lag_valid_ff;

   always_comb begin
      sts.op        = op_ff;
      sts.full      = (count_ff >= eff_limit);
      sts.pos_ok    = (CNT_W'(pos_ff) < count_ff);
      sts.hit       = hit;
      sts.miss      = exhausted && !hit;
      sts.shift_end = exhausted && !lag_valid_ff;
   end

   // scan pointer, with a lagging index that tracks the registered read
   always_comb begin
      ptr_in       = ptr_ff;
      lag_idx_in   = lag_idx_ff;
      lag_valid_in = lag_valid_ff;
      if (cmd.scan_begin) begin
         ptr_in       = '0;
         lag_valid_in = 1'b0;
      end else if (cmd.seek_pos) begin
         ptr_in = CNT_W'(pos_ff);
      end else if (cmd.shift_begin) begin
         ptr_in       = lag_idx_ff + CNT_W'(1);
         lag_valid_in = 1'b0;
      end else if (cmd.step) begin
         if (!exhausted) begin
            ptr_in       = ptr_ff + CNT_W'(1);
            lag_idx_in   = ptr_ff;
            lag_valid_in = 1'b1;
         end else begin
            lag_valid_in = 1'b0;
         end
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.wr_append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         lag_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         lag_valid_ff <= lag_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      lag_idx_ff <= lag_idx_in;
   end

   // store write port selection
   assign shift_dst = lag_idx_ff - CNT_W'(1);
   assign key_wr_en = cmd.wr_append || shift_move;
   assign val_wr_en = cmd.wr_append || cmd.wr_update || shift_move;

   always_comb begin
      if (cmd.wr_append) begin
         wr_addr     = count_ff[IDX_W-1:0];
         key_wr_data = key_ff;
         val_wr_data = val_ff;
      end else if (cmd.wr_update) begin
         wr_addr     = lag_idx_ff[IDX_W-1:0];
         key_wr_data = key_ff;
         val_wr_data = val_ff;
      end else begin
         wr_addr     = shift_dst[IDX_W-1:0];
         key_wr_data = key_rd;
         val_wr_data = val_rd;
      end
   end

   okvt_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_wr_data),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (key_rd)
   );

   okvt_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (val_rd)
   );

   // result collected during the operation
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         res_ok_ff  <= 1'b0;
         res_key_ff <= '0;
         res_val_ff <= '0;
      end else begin
         if (cmd.set_ok) begin
            res_ok_ff <= 1'b1;
         end
         if (cmd.cap_entry) begin
            res_key_ff <= key_rd;
         end
         if (cmd.cap_entry || cmd.cap_value) begin
            res_val_ff <= val_rd;
         end
      end
   end

   // response beat register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_key_ff   <= res_key_ff;
         rsp_val_ff   <= res_val_ff;
         rsp_count_ff <= count_ff;
         rsp_empty_ff <= (count_ff == '0);
      end
   end

   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found_key   = rsp_key_ff;
   assign rsp_found_value = rsp_val_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");
   a_dec_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.count_dec |-> count_ff != '0)
      else $error("erase with an empty table");
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not raise the count");
`endif

endmodule
